[sv/fan_speed_from_temperature_top_assert.svh]
// ----------------------------------------------------------------------------
// Fan speed assertion macros
// Short forms for the concurrent checks at the end of the fan speed top level.
// ----------------------------------------------------------------------------
`ifndef FAN_SPEED_FROM_TEMPERATURE_TOP_ASSERT_SVH
`define FAN_SPEED_FROM_TEMPERATURE_TOP_ASSERT_SVH

// The consequent must hold on the same edge as the antecedent.
`define FSPD_ASSERT_NOW(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold on the edge after the antecedent.
`define FSPD_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/fspd_pkg.sv]
// ----------------------------------------------------------------------------
// Fan speed package
// Codes, constants and register reset values of the fan speed controller.
// ----------------------------------------------------------------------------
package fspd_pkg;

  // Result kinds carried in the action field.
  typedef enum logic [1:0] {
    ACT_OFF  = 2'd0,
    ACT_CRIT = 2'd1,
    ACT_RAMP = 2'd2
  } action_t;

  // Configuration register indexes.
  typedef enum logic [3:0] {
    REG_OFF_THRESHOLD = 4'd0,
    REG_CRITICAL      = 4'd1,
    REG_SAFE          = 4'd2,
    REG_MIN_SPEED     = 4'd3,
    REG_MAX_SPEED     = 4'd4,
    REG_STEP_SCALE    = 4'd5,
    REG_SLOWEST       = 4'd6,
    REG_FASTEST       = 4'd7
  } reg_index_t;

  localparam logic signed [8:0] HOLD_TICKS = 9'sd20;

  localparam logic [7:0] SPEED_OFF  = 8'hFF;
  localparam logic [7:0] SPEED_CRIT = 8'h66;

  // Width of the dividend in the shared divider; the ramp product needs 24 bits.
  localparam int DIV_W = 24;

  localparam logic [7:0] RST_OFF_THRESHOLD = 8'd45;
  localparam logic [7:0] RST_CRITICAL      = 8'd75;
  localparam logic [7:0] RST_SAFE          = 8'd40;
  localparam logic [7:0] RST_MIN_SPEED     = 8'd0;
  localparam logic [7:0] RST_MAX_SPEED     = 8'd24;
  localparam logic [7:0] RST_STEP_SCALE    = 8'd1;
  localparam logic [7:0] RST_SLOWEST       = 8'd126;
  localparam logic [7:0] RST_FASTEST       = 8'd102;

endpackage

[sv/fan_speed_from_temperature_top.sv]
// ----------------------------------------------------------------------------
// Fan speed from temperature
// Turns one temperature reading per control tick into a fan speed byte.
// ----------------------------------------------------------------------------
// Usage: each word on the s_t* channel is one control tick carrying an 8-bit
// temperature. For every accepted word exactly one result word leaves on the
// m_t* channel with the action (off, critical, ramp), the speed byte and the
// long delay flag. The cfg_* channel writes the eight 8-bit registers; it is
// always ready and must only be used while the block is idle. Indexes past
// the last register are ignored.
// Timing: an off or critical tick resolves at once and goes from IDLE to
// OUTPUT, where the word enters the output register as m_tvalid rises and
// s_tready returns at the same time, unless the receiver stalls. A ramp tick
// runs one shared restoring divider twice over the 24-bit dividend (slope,
// then the scaled product by max speed), with the multiply states MUL1 and
// MUL2 between and the clamp state FIN after, then OUTPUT. s_tready is high
// only while the sequencer is idle, so one tick is in flight at a time.
// Reset (synchronous, active high) restores the register defaults, reloads
// the hold counter and marks the fan as running. When the receiver stalls,
// the finished result waits in the sequencer, and a word already in the
// output register holds until it is taken.
// ----------------------------------------------------------------------------
`include "fan_speed_from_temperature_top_assert.svh"

module fan_speed_from_temperature_top (
  input  logic        clk,
  input  logic        rst,
  // Input ticks.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] temperature
  // Results.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [1:0] action, [9:2] speed_code, [10] long_delay
  // Register writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import fspd_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    SLOPE,
    MUL1,
    MUL2,
    QUOT,
    FIN,
    OUTPUT
  } state_t;

  localparam logic [4:0] DIV_LAST = 5'(DIV_W - 1);

  state_t state;

  // Configuration registers.
  logic [7:0] off_threshold_temp;
  logic [7:0] critical_temp;
  logic [7:0] safe_temp;
  logic [7:0] min_speed_units;
  logic [7:0] max_speed_units;
  logic [7:0] step_scale;
  logic [7:0] slowest_code;
  logic [7:0] fastest_code;

  // Tick state.
  logic signed [8:0] hold_counter;
  logic              fan_is_off;

  // Work registers of the ramp.
  logic [7:0]       diff_mag;
  logic             slope_neg;
  logic             res_neg;
  logic             den_zero;
  logic [15:0]      prod16;
  logic [1:0]       res_action;
  logic [7:0]       res_code;
  logic             res_long;

  // Shared divider.
  logic [7:0]       div_rem;
  logic [DIV_W-1:0] div_quo;
  logic [7:0]       div_den;
  logic [4:0]       div_cnt;

  // Output register.
  logic [1:0]       m_action;
  logic [7:0]       m_code;
  logic             m_long;

  logic              accept;
  logic signed [8:0] hc_dec;
  logic              go_off;
  logic              go_crit;
  logic [8:0]        num;
  logic [8:0]        den;
  logic [8:0]        diff;
  logic [8:0]        num_abs;
  logic [8:0]        den_abs;
  logic [8:0]        diff_abs;
  logic [8:0]        div_shift;
  logic [8:0]        div_sub;
  logic              div_ge;
  logic [7:0]        slope_mag;
  logic [7:0]        quo8;
  logic [7:0]        step8;
  logic [7:0]        code_raw;
  logic [7:0]        code_clamped;

  assign s_tready  = (state == IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign m_tdata   = {5'd0, m_long, m_code, m_action};

  // The hold counter counts down first and sticks at minus one.
  assign hc_dec  = (hold_counter > -9'sd1) ? (hold_counter - 9'sd1) : hold_counter;
  assign go_off  = (s_tdata < off_threshold_temp) && (hc_dec[8] || fan_is_off);
  assign go_crit = (s_tdata > critical_temp);

  // Signed operands of the ramp, split into sign and magnitude.
  assign num      = {1'b0, max_speed_units} - {1'b0, min_speed_units};
  assign den      = {1'b0, critical_temp} - {1'b0, safe_temp};
  assign diff     = {1'b0, s_tdata} - {1'b0, safe_temp};
  assign num_abs  = num[8] ? (9'd0 - num) : num;
  assign den_abs  = den[8] ? (9'd0 - den) : den;
  assign diff_abs = diff[8] ? (9'd0 - diff) : diff;

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  assign div_shift = {div_rem, div_quo[DIV_W-1]};
  assign div_sub   = div_shift - {1'b0, div_den};
  assign div_ge    = (div_shift >= {1'b0, div_den});

  // A zero divisor gives a zero slope.
  assign slope_mag = den_zero ? 8'd0 : div_quo[7:0];

  // Only the low byte of the truncated quotient reaches the speed byte.
  always_comb begin
    if (max_speed_units == 8'd0) begin
      quo8 = 8'd0;
    end else if (res_neg) begin
      quo8 = 8'd0 - div_quo[7:0];
    end else begin
      quo8 = div_quo[7:0];
    end
    step8    = min_speed_units + quo8;
    code_raw = slowest_code - step8;
    // The lower clamp is tested first and wins if the two limits cross.
    priority if (code_raw < fastest_code) begin
      code_clamped = fastest_code;
    end else if (code_raw > slowest_code) begin
      code_clamped = slowest_code;
    end else begin
      code_clamped = code_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= IDLE;
      m_tvalid           <= 1'b0;
      hold_counter       <= HOLD_TICKS;
      fan_is_off         <= 1'b0;
      off_threshold_temp <= RST_OFF_THRESHOLD;
      critical_temp      <= RST_CRITICAL;
      safe_temp          <= RST_SAFE;
      min_speed_units    <= RST_MIN_SPEED;
      max_speed_units    <= RST_MAX_SPEED;
      step_scale         <= RST_STEP_SCALE;
      slowest_code       <= RST_SLOWEST;
      fastest_code       <= RST_FASTEST;
    end else begin
      // In the output state the word is handed over below instead.
      if (m_tvalid && m_tready && (state != OUTPUT)) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_OFF_THRESHOLD: off_threshold_temp <= cfg_data;
          REG_CRITICAL:      critical_temp      <= cfg_data;
          REG_SAFE:          safe_temp          <= cfg_data;
          REG_MIN_SPEED:     min_speed_units    <= cfg_data;
          REG_MAX_SPEED:     max_speed_units    <= cfg_data;
          REG_STEP_SCALE:    step_scale         <= cfg_data;
          REG_SLOWEST:       slowest_code       <= cfg_data;
          REG_FASTEST:       fastest_code       <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        IDLE: begin
          if (accept) begin
            if (go_off) begin
              fan_is_off   <= 1'b1;
              hold_counter <= HOLD_TICKS;
              res_action   <= ACT_OFF;
              res_code     <= SPEED_OFF;
              res_long     <= 1'b0;
              state        <= OUTPUT;
            end else if (go_crit) begin
              fan_is_off   <= 1'b0;
              hold_counter <= hc_dec;
              res_action   <= ACT_CRIT;
              res_code     <= SPEED_CRIT;
              res_long     <= 1'b1;
              state        <= OUTPUT;
            end else begin
              fan_is_off   <= 1'b0;
              hold_counter <= hc_dec;
              res_action   <= ACT_RAMP;
              res_long     <= 1'b1;
              diff_mag     <= diff_abs[7:0];
              slope_neg    <= num[8] ^ den[8];
              den_zero     <= (den == 9'd0);
              res_neg      <= diff[8];
              div_quo      <= DIV_W'(num_abs[7:0]);
              div_den      <= den_abs[7:0];
              div_rem      <= 8'd0;
              div_cnt      <= 5'd0;
              state        <= SLOPE;
            end
          end
        end
        SLOPE: begin
          div_rem <= div_ge ? div_sub[7:0] : div_shift[7:0];
          div_quo <= {div_quo[DIV_W-2:0], div_ge};
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == DIV_LAST) begin
            state <= MUL1;
          end
        end
        MUL1: begin
          prod16  <= slope_mag * diff_mag;
          res_neg <= res_neg ^ slope_neg;
          state   <= MUL2;
        end
        MUL2: begin
          div_quo <= DIV_W'(prod16 * step_scale);
          div_den <= max_speed_units;
          div_rem <= 8'd0;
          div_cnt <= 5'd0;
          state   <= QUOT;
        end
        QUOT: begin
          div_rem <= div_ge ? div_sub[7:0] : div_shift[7:0];
          div_quo <= {div_quo[DIV_W-2:0], div_ge};
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == DIV_LAST) begin
            state <= FIN;
          end
        end
        FIN: begin
          res_code <= code_clamped;
          state    <= OUTPUT;
        end
        OUTPUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_action <= res_action;
            m_code   <= res_code;
            m_long   <= res_long;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // A tick is taken only with the sequencer idle, so it never takes two in a row.
  `FSPD_ASSERT_NEXT(a_one_in_flight, clk, rst, accept, !s_tready,
    "input accepted while a tick was still in flight")
  // The hold counter never leaves its range.
  `FSPD_ASSERT_NOW(a_hold_range, clk, rst, 1'b1,
    (hold_counter >= -9'sd1) && (hold_counter <= HOLD_TICKS),
    "hold counter out of range")
  // A fan off result always carries the off speed byte and a short delay.
  `FSPD_ASSERT_NOW(a_off_word, clk, rst, m_tvalid && (m_tdata[1:0] == ACT_OFF),
    (m_tdata[9:2] == SPEED_OFF) && !m_tdata[10],
    "fan off result with wrong speed byte or delay")

endmodule
